FILE: rtl/rspt_pkg.sv
// Package for the region stride prefetch table: widths, codes, state encoding
// and the structs passed between the top level and the row of table cells.
// No dependencies.
package rspt_pkg;

   // Address and line geometry
   localparam int ADDR_W     = 48;
   localparam int LINE_SHIFT = 6;
   localparam int LINE_W     = ADDR_W - LINE_SHIFT;
   localparam int DIFF_W     = LINE_W + 1;
   localparam int CAND_W     = ADDR_W + 2;

   // Table entry fields
   localparam int TABLE_ENTRIES = 16;
   localparam int STRIDE_W      = 11;
   localparam int CONF_W        = 2;
   localparam int NEAR_LINES    = 512 >> LINE_SHIFT;

   localparam logic [STRIDE_W-1:0] INIT_STRIDE = STRIDE_W'(64);
   localparam logic [CONF_W-1:0]   CONF_MAX    = CONF_W'(3);
   localparam logic [CONF_W-1:0]   CONF_FIRE   = CONF_W'(2);
   localparam logic [CONF_W-1:0]   CONF_ONE    = CONF_W'(1);
   localparam logic [CONF_W-1:0]   CONF_ZERO   = CONF_W'(0);

   // Prediction degree
   localparam int MAX_DEGREE = 8;
   localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
   localparam int CFG_DEG_W  = 4;
   localparam logic [CFG_DEG_W-1:0] RESET_DEGREE = CFG_DEG_W'(4);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE     = 2'd0,
      CSR_REGION_END      = 2'd1,
      CSR_PREFETCH_DEGREE = 2'd2
   } csr_index_type;

   // Top-level sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DECIDE,
      ST_GEN,
      ST_FLUSH
   } state_type;

   // Command broadcast from the sequencer to every cell
   typedef struct packed {
      logic              look;
      logic              update;
      logic              alloc;
      logic              any_free;
      logic [LINE_W-1:0] line;
   } cell_cmd_type;

   // Priority token handed from cell to cell along the row
   typedef struct packed {
      logic                head;
      logic                decided;
      logic                hit;
      logic                free_seen;
      logic [CONF_W-1:0]   conf;
      logic [STRIDE_W-1:0] stride;
   } chain_type;

endpackage

FILE: rtl/rspt_req_if.sv
// Request channel of the region stride prefetch table: one access address.
// Depends on rspt_pkg.
interface rspt_req_if import rspt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] access_addr;

   modport source (output valid, output access_addr, input ready);
   modport sink (input valid, input access_addr, output ready);
endinterface

FILE: rtl/rspt_rsp_if.sv
// Response channel of the region stride prefetch table: one predicted line.
// Depends on rspt_pkg.
interface rspt_rsp_if import rspt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] prefetch_addr;
   logic              last_of_run;

   modport source (output valid, output prefetch_addr, output last_of_run, input ready);
   modport sink (input valid, input prefetch_addr, input last_of_run, output ready);
endinterface

FILE: rtl/rspt_csr_if.sv
// Configuration write channel of the region stride prefetch table.
// Depends on rspt_pkg.
interface rspt_csr_if import rspt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rspt_cell.sv
// One stride table entry: classifies the broadcast line against its entry,
// passes the priority token on to the next cell and applies its own update.
// Depends on rspt_pkg.
module rspt_cell import rspt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  chain_type    chain_in,
   output chain_type    chain_out,
   output logic         valid,
   output logic         write
);

   localparam int SL_W = STRIDE_W - LINE_SHIFT;
   localparam logic signed [DIFF_W-1:0] NEAR_HI = DIFF_W'(NEAR_LINES);
   localparam logic signed [DIFF_W-1:0] NEAR_LO = -NEAR_HI;

   logic                valid_ff, valid_in;
   logic [LINE_W-1:0]   last_ff, last_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [CONF_W-1:0]   conf_ff, conf_in;
   logic                hit_ff, hit_in;
   logic                match_ff, match_in;
   logic                near_ff, near_in;
   logic [STRIDE_W-1:0] near_stride_ff, near_stride_in;

   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] stride_lines;
   logic                     hit_now;
   logic [CONF_W-1:0]        conf_inc;
   logic                     upd_mine;
   logic                     claim;

   // Compare the broadcast line with this entry, in lines
   assign diff         = DIFF_W'({1'b0, cmd.line}) - DIFF_W'({1'b0, last_ff});
   assign stride_lines = {{(DIFF_W-SL_W){stride_ff[STRIDE_W-1]}},
                          stride_ff[STRIDE_W-1:LINE_SHIFT]};
   assign hit_now      = valid_ff && (last_ff == cmd.line);

   // Latch the classification during the look cycle
   always_comb begin
      hit_in         = hit_ff;
      match_in       = match_ff;
      near_in        = near_ff;
      near_stride_in = near_stride_ff;
      if (cmd.look) begin
         hit_in         = hit_now;
         match_in       = valid_ff && !hit_now
                          && (stride_ff[LINE_SHIFT-1:0] == '0) && (diff == stride_lines);
         near_in        = valid_ff && !hit_now && (diff >= NEAR_LO) && (diff <= NEAR_HI);
         near_stride_in = {diff[SL_W-1:0], {LINE_SHIFT{1'b0}}};
      end
   end

   assign conf_inc = (conf_ff == CONF_MAX) ? CONF_MAX : conf_ff + CONF_ONE;

   // Pass the token on; the first deciding cell stamps its outcome into it
   always_comb begin
      chain_out           = chain_in;
      chain_out.head      = 1'b0;
      chain_out.free_seen = chain_in.free_seen || !valid_ff;
      if (!chain_in.decided && (hit_ff || match_ff || near_ff)) begin
         chain_out.decided = 1'b1;
         chain_out.hit     = hit_ff;
         chain_out.conf    = match_ff ? conf_inc : CONF_ONE;
         chain_out.stride  = match_ff ? stride_ff : near_stride_ff;
      end
   end

   // Own update: retrain when this cell decided, claim on a table miss
   assign upd_mine = cmd.update && !chain_in.decided && !hit_ff && (match_ff || near_ff);
   assign claim    = cmd.update && cmd.alloc
                     && ((!valid_ff && !chain_in.free_seen) || (!cmd.any_free && chain_in.head));
   assign write    = upd_mine || claim;
   assign valid    = valid_ff;

   always_comb begin
      valid_in  = valid_ff;
      last_in   = last_ff;
      stride_in = stride_ff;
      conf_in   = conf_ff;
      if (claim) begin
         valid_in  = 1'b1;
         last_in   = cmd.line;
         stride_in = INIT_STRIDE;
         conf_in   = CONF_ZERO;
      end else if (upd_mine) begin
         last_in   = cmd.line;
         stride_in = chain_out.stride;
         conf_in   = chain_out.conf;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         match_ff <= 1'b0;
         near_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         match_ff <= match_in;
         near_ff  <= near_in;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      last_ff        <= last_in;
      stride_ff      <= stride_in;
      conf_ff        <= conf_in;
      near_stride_ff <= near_stride_in;
   end

endmodule

FILE: rtl/rspt_chain.sv
// Row of stride table cells linked by the priority token; the token leaving
// the last cell is the table's verdict. Depends on rspt_pkg and rspt_cell.
module rspt_chain import rspt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   output chain_type    result
);

   chain_type                links [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] valid_vec;
   logic [TABLE_ENTRIES-1:0] write_vec;

   // Seed the token at the head of the row
   always_comb begin
      links[0]      = '0;
      links[0].head = 1'b1;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      rspt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (links[i]),
         .chain_out (links[i+1]),
         .valid     (valid_vec[i]),
         .write     (write_vec[i])
      );
   end

   assign result = links[TABLE_ENTRIES];

   // At most one entry is written per request
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(write_vec))
      else $error("more than one table entry written");

   // A miss always claims exactly one entry
   a_alloc_claims: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cmd.alloc && (cmd.any_free == result.free_seen)) |-> $onehot(write_vec))
      else $error("table miss did not claim exactly one entry");

   // A line hit leaves the table untouched
   a_hit_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && result.decided && result.hit) |-> (write_vec == '0))
      else $error("table written on a line hit");

   // A claimed free entry is valid afterwards
   a_claim_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cmd.alloc && (write_vec != '0)) |=> ((valid_vec & $past(write_vec)) != '0))
      else $error("claimed entry not valid");

endmodule

FILE: rtl/region_stride_prefetch_table.sv
// Top level of the region stride prefetch table: configuration registers,
// request sequencer, prediction generator and response register.
// Depends on rspt_pkg, the rspt_*_if interfaces and rspt_chain.
//
//   Channel  Dir   Handshake      Payload
//   req_ch   in    valid/ready    access_addr[47:0]
//   rsp_ch   out   valid/ready    prefetch_addr[47:0], last_of_run
//   csr_ch   in    valid/ready    index[1:0], data[47:0] (ready always high)
//
// An access outside the region is taken in idle and dropped. Every other
// access passes look and decide through the cell row, then generate and
// flush when the entry is confident: the generator forms one candidate line
// per cycle and the last kept line leaves from a one-entry holding register.
// A stalled response holds the generator. Reset is synchronous and clears
// all entry valid bits at once; degree resets to 4, region bounds to 0.
module region_stride_prefetch_table import rspt_pkg::*; (
   input logic   clock,
   input logic   reset,
   rspt_req_if.sink   req_ch,
   rspt_rsp_if.source rsp_ch,
   rspt_csr_if.sink   csr_ch
);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [ADDR_W-1:0]    end_ff, end_in;
   logic [CFG_DEG_W-1:0] degree_ff, degree_in;

   logic [LINE_W-1:0]  line_ff, line_in;
   logic [DEG_W-1:0]   deg_ff, deg_in;
   logic [DEG_W-1:0]   cnt_ff, cnt_in;
   logic [CAND_W-1:0]  stride_ff, stride_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_cmd_type cmd;
   chain_type    result;

   logic              accept;
   logic              in_region;
   logic [DEG_W-1:0]  deg_now;
   logic [CAND_W-1:0] stride_ext;
   logic              fire;
   logic              keep;
   logic              out_free;
   logic              step_ok;
   logic              push;
   logic              push_last;

   rspt_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (result)
   );

   // Request and region checks
   assign accept    = req_ch.valid && req_ch.ready;
   assign in_region = (req_ch.access_addr >= base_ff) && (req_ch.access_addr < end_ff);

   // Saturate the configured degree
   always_comb begin
      if (int'(degree_ff) > MAX_DEGREE) begin
         deg_now = DEG_W'(MAX_DEGREE);
      end else begin
         deg_now = DEG_W'(degree_ff);
      end
   end

   assign stride_ext = {{(CAND_W-STRIDE_W){result.stride[STRIDE_W-1]}}, result.stride};
   assign fire       = result.decided && !result.hit && (result.conf >= CONF_FIRE)
                       && (result.stride != '0) && (deg_now != '0);

   // Candidate screening and response stall
   assign keep     = (cand_ff[CAND_W-1:ADDR_W] == '0)
                     && (cand_ff[ADDR_W-1:0] >= base_ff) && (cand_ff[ADDR_W-1:0] < end_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign step_ok  = !(keep && pend_valid_ff && !out_free);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_region) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = fire ? ST_GEN : ST_IDLE;
         end
         ST_GEN: begin
            if (step_ok && (cnt_ff == deg_ff)) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      cmd          = '0;
      cmd.line     = line_ff;
      cmd.alloc    = !result.decided;
      cmd.any_free = result.free_seen;
      push         = 1'b0;
      push_last    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
         end
         ST_DECIDE: begin
            cmd.update = 1'b1;
         end
         ST_GEN: begin
            push = step_ok && keep && pend_valid_ff;
         end
         ST_FLUSH: begin
            push      = pend_valid_ff && out_free;
            push_last = 1'b1;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      base_in   = base_ff;
      end_in    = end_ff;
      degree_in = degree_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_REGION_BASE:     base_in   = csr_ch.data;
            CSR_REGION_END:      end_in    = csr_ch.data;
            CSR_PREFETCH_DEGREE: degree_in = csr_ch.data[CFG_DEG_W-1:0];
            default:             base_in   = base_ff;
         endcase
      end
   end

   // Datapath: capture line, seed and advance the candidate, hold the pending line
   always_comb begin
      line_in       = line_ff;
      deg_in        = deg_ff;
      cnt_in        = cnt_ff;
      stride_in     = stride_ff;
      cand_in       = cand_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      if (accept) begin
         line_in = req_ch.access_addr[ADDR_W-1:LINE_SHIFT];
      end
      if (state_ff == ST_DECIDE) begin
         deg_in        = deg_now;
         cnt_in        = DEG_W'(1);
         stride_in     = stride_ext;
         cand_in       = {2'b00, line_ff, {LINE_SHIFT{1'b0}}} + stride_ext;
         pend_valid_in = 1'b0;
      end
      if ((state_ff == ST_GEN) && step_ok) begin
         cnt_in  = cnt_ff + DEG_W'(1);
         cand_in = cand_ff + stride_ff;
         if (keep) begin
            pend_valid_in = 1'b1;
            pend_addr_in  = cand_ff[ADDR_W-1:0];
         end
      end
      if ((state_ff == ST_FLUSH) && push) begin
         pend_valid_in = 1'b0;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = pend_addr_ff;
         rsp_last_in  = push_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.prefetch_addr = rsp_addr_ff;
   assign rsp_ch.last_of_run   = rsp_last_ff;

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         end_ff        <= '0;
         degree_ff     <= RESET_DEGREE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         end_ff        <= end_in;
         degree_ff     <= degree_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      line_ff      <= line_in;
      deg_ff       <= deg_in;
      cnt_ff       <= cnt_in;
      stride_ff    <= stride_in;
      cand_ff      <= cand_in;
      pend_addr_ff <= pend_addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // The closing response of a run returns the sequencer to idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after the last response of a run");

   // The generator never runs past the degree
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN) |-> ((cnt_ff != '0) && (cnt_ff <= deg_ff)))
      else $error("candidate count out of range");

   // Responses are loaded only while generating or flushing
   a_push_state: assert property (@(posedge clock) disable iff (reset)
      push |-> ((state_ff == ST_GEN) || (state_ff == ST_FLUSH)))
      else $error("response loaded outside generation");

   // No request is taken while a run is still in flight
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!pend_valid_ff || (state_ff == ST_IDLE)))
      else $error("request accepted during a run");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for region_stride_prefetch_table: drives access requests,
// predicts the prefetched lines from its own copy of the stride table and checks
// every response in order. Depends on rspt_pkg and the rspt_*_if interfaces.
module tb_top;
   import rspt_pkg::*;

   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 200;
   localparam int IDLE_PERCENT  = 13;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              last;
   } prefetch_type;

   logic clock = 1'b0;
   logic reset;

   rspt_req_if req_ch ();
   rspt_rsp_if rsp_ch ();
   rspt_csr_if csr_ch ();

   region_stride_prefetch_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // Shadow configuration and stride table
   logic [ADDR_W-1:0]    cfg_base   = '0;
   logic [ADDR_W-1:0]    cfg_end    = '0;
   logic [CFG_DEG_W-1:0] cfg_degree = RESET_DEGREE;

   logic                tbl_valid  [TABLE_ENTRIES] = '{default: 1'b0};
   logic [LINE_W-1:0]   tbl_line   [TABLE_ENTRIES];
   logic [STRIDE_W-1:0] tbl_stride [TABLE_ENTRIES];
   logic [CONF_W-1:0]   tbl_conf   [TABLE_ENTRIES];

   logic [ADDR_W-1:0] access_queue [$];
   prefetch_type      expected_lines [$];

   int n_offered  = 0;
   int n_accepted = 0;
   int n_errors   = 0;

   logic calm     = 1'b0;
   logic hold_go  = 1'b0;
   logic hold_used;
   int   hold_left;

   prefetch_type got_line;
   prefetch_type want_line;

   function automatic logic in_region(logic [ADDR_W-1:0] addr);
      return addr >= cfg_base && addr < cfg_end;
   endfunction

   function automatic longint stride_of(logic [STRIDE_W-1:0] s);
      return longint'($signed(s));
   endfunction

   // Update the shadow table for one access and queue the lines it predicts
   function automatic void predict_prefetches(logic [ADDR_W-1:0] addr);
      logic [LINE_W-1:0] line;
      logic [ADDR_W-1:0] kept_addr [MAX_DEGREE];
      longint line_bytes, delta, step_bytes, cand;
      int i, d, pick, first_free, kept, deg;
      prefetch_type item;

      pick = -1;
      first_free = -1;
      kept = 0;
      if (!in_region(addr)) return;
      line = addr[ADDR_W-1:LINE_SHIFT];
      line_bytes = longint'({16'b0, line, 6'b0});

      for (i = 0; i < TABLE_ENTRIES; i++) begin
         if (!tbl_valid[i]) begin
            if (first_free < 0) first_free = i;
            continue;
         end
         // exact line hit ends the step
         if (tbl_line[i] == line) return;
         delta = line_bytes - longint'({16'b0, tbl_line[i], 6'b0});
         if (delta != 0 && delta == stride_of(tbl_stride[i])) begin
            if (tbl_conf[i] < CONF_MAX) tbl_conf[i] = tbl_conf[i] + CONF_ONE;
            tbl_line[i] = line;
            pick = i;
            break;
         end
         if (delta != 0 && delta <= (NEAR_LINES << LINE_SHIFT)
             && delta >= -(NEAR_LINES << LINE_SHIFT)) begin
            tbl_stride[i] = delta[STRIDE_W-1:0];
            tbl_conf[i] = CONF_ONE;
            tbl_line[i] = line;
            pick = i;
            break;
         end
      end

      // miss: claim the first free entry, else replace entry 0
      if (pick < 0) begin
         pick = (first_free >= 0) ? first_free : 0;
         tbl_valid[pick] = 1'b1;
         tbl_line[pick] = line;
         tbl_stride[pick] = INIT_STRIDE;
         tbl_conf[pick] = CONF_ZERO;
         return;
      end

      step_bytes = stride_of(tbl_stride[pick]);
      if (tbl_conf[pick] < CONF_FIRE || step_bytes == 0) return;
      deg = (cfg_degree > MAX_DEGREE) ? MAX_DEGREE : int'(cfg_degree);

      // drop candidates outside the address space or the region
      for (d = 1; d <= deg; d++) begin
         cand = line_bytes + step_bytes * d;
         if (cand < 0 || cand >= (longint'(1) << ADDR_W)) continue;
         if (!in_region(cand[ADDR_W-1:0])) continue;
         kept_addr[kept] = cand[ADDR_W-1:0];
         kept++;
      end
      for (i = 0; i < kept; i++) begin
         item.addr = kept_addr[i];
         item.last = (i == kept - 1);
         expected_lines = {expected_lines, item};
      end
   endfunction

   function automatic void log_mismatch(string what, prefetch_type want, prefetch_type got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%0t %s: expected addr %h last %b, got addr %h last %b",
                  $realtime, what, want.addr, want.last, got.addr, got.last);
   endfunction

   // Request driver: predict on acceptance, then offer the next access
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_prefetches(req_ch.access_addr);
            n_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (access_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_ch.valid <= 1'b1;
               req_ch.access_addr <= access_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long response hold-off, started once on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: compare each accepted prefetch with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_line.addr = rsp_ch.prefetch_addr;
            got_line.last = rsp_ch.last_of_run;
            if (expected_lines.size() == 0) begin
               log_mismatch("unexpected prefetch", '0, got_line);
            end else begin
               want_line = expected_lines.pop_front();
               if (got_line.addr !== want_line.addr || got_line.last !== want_line.last)
                  log_mismatch("prefetch mismatch", want_line, got_line);
            end
         end
         rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] rand_between(logic [ADDR_W-1:0] lo,
                                                       logic [ADDR_W-1:0] hi);
      if (hi > lo) return lo + rand_addr() % (hi - lo);
      return rand_addr();
   endfunction

   function automatic void offer(logic [ADDR_W-1:0] addr);
      access_queue = {access_queue, addr};
      n_offered++;
   endfunction

   // Queue one strided run of accesses; now and then repeat a line to break it
   function automatic int add_stream(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      logic [ADDR_W-1:0] start_line, step;
      int len, i;
      start_line = rand_between(lo, hi) & ~ADDR_W'(63);
      step = ADDR_W'($urandom_range(8, 1) * 64);
      if ($urandom_range(1) != 0) step = -step;
      len = $urandom_range(7, 3);
      for (i = 0; i < len; i++) begin
         if (i == 2 && $urandom_range(4) == 0)
            offer(start_line + ADDR_W'(i - 1) * step + ADDR_W'($urandom_range(63)));
         else
            offer(start_line + ADDR_W'(i) * step + ADDR_W'($urandom_range(63)));
      end
      return len;
   endfunction

   task automatic random_phase(int count, logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 75) begin
            n += add_stream(lo, hi);
         end else begin
            offer(($urandom_range(1) != 0) ? rand_between(lo, hi) : rand_addr());
            n++;
         end
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_REGION_BASE:     cfg_base = value;
         CSR_REGION_END:      cfg_end = value;
         CSR_PREFETCH_DEGREE: cfg_degree = value[CFG_DEG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait until every access is taken and every prefetch has come back
   task automatic settle();
      while (n_accepted != n_offered || expected_lines.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.access_addr = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_REGION_BASE;
      csr_ch.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty region straight out of reset
      offer('0);
      offer('1);
      offer(ADDR_W'(48'h1234));
      settle();

      // low region, degree above the maximum
      write_csr(CSR_REGION_BASE, '0);
      write_csr(CSR_REGION_END, ADDR_W'(48'h10_0000));
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(15));
      offer(ADDR_W'(48'h10_0000));
      // falling stride running below address zero, then a same-line hit
      offer(ADDR_W'(48'h100));
      offer(ADDR_W'(48'hC0));
      offer(ADDR_W'(48'h80));
      offer(ADDR_W'(48'h40));
      offer(ADDR_W'(48'h7F));
      // rising stride running past the region end
      offer(ADDR_W'(48'hF_FE00));
      offer(ADDR_W'(48'hF_FE40));
      offer(ADDR_W'(48'hF_FE80));
      // widest near stride
      offer(ADDR_W'(48'h8000));
      offer(ADDR_W'(48'h8200));
      offer(ADDR_W'(48'h8400));
      settle();

      // degree zero still trains the table
      write_csr(CSR_PREFETCH_DEGREE, '0);
      offer(ADDR_W'(48'h8600));
      settle();

      // top of the address space
      write_csr(CSR_REGION_BASE, ADDR_W'(48'hFFFF_FFFF_F000));
      write_csr(CSR_REGION_END, '1);
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(8));
      offer(ADDR_W'(48'hFFFF_FFFF_FE00));
      offer(ADDR_W'(48'hFFFF_FFFF_FE40));
      offer(ADDR_W'(48'hFFFF_FFFF_FE80));
      settle();
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(1));
      offer(ADDR_W'(48'hFFFF_FFFF_FEC0));
      settle();

      // random streams, no idling on either side
      write_csr(CSR_REGION_BASE, ADDR_W'(48'h4000));
      write_csr(CSR_REGION_END, ADDR_W'(48'h4_0000));
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(4));
      calm <= 1'b1;
      random_phase(30, ADDR_W'(48'h4000), ADDR_W'(48'h4_0000));
      settle();
      calm <= 1'b0;

      // whole address space, full degree, responses held off for a while
      write_csr(CSR_REGION_BASE, '0);
      write_csr(CSR_REGION_END, '1);
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(8));
      random_phase(30, '0, '1);
      hold_go <= 1'b1;
      settle();

      // random bounds, possibly empty, random degree with junk upper bits
      begin
         logic [ADDR_W-1:0] lo, hi;
         lo = rand_addr();
         hi = ($urandom_range(1) != 0) ? rand_addr() : lo + ADDR_W'($urandom_range(1 << 20));
         write_csr(CSR_REGION_BASE, lo);
         write_csr(CSR_REGION_END, hi);
         write_csr(CSR_PREFETCH_DEGREE, {rand_addr()} & ~ADDR_W'(15) | ADDR_W'($urandom_range(15)));
         random_phase(25, lo, hi);
         settle();
      end

      // high region, low degree
      write_csr(CSR_REGION_BASE, ADDR_W'(48'hFFFF_FFF0_0000));
      write_csr(CSR_REGION_END, '1);
      write_csr(CSR_PREFETCH_DEGREE, ADDR_W'(2));
      random_phase(20, ADDR_W'(48'hFFFF_FFF0_0000), '1);
      settle();

      if (n_errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: region_stride_prefetch_table.f
rtl/rspt_pkg.sv
rtl/rspt_req_if.sv
rtl/rspt_rsp_if.sv
rtl/rspt_csr_if.sv
rtl/rspt_cell.sv
rtl/rspt_chain.sv
rtl/region_stride_prefetch_table.sv
tb/tb_top.sv
